>>> rtl/sum_of_sines_wave_vertex_macros.svh
// Assertion macros shared by the wave vertex RTL.
`ifndef SUM_OF_SINES_WAVE_VERTEX_MACROS_SVH
`define SUM_OF_SINES_WAVE_VERTEX_MACROS_SVH

// Same-cycle implication, checked on clk_i and off during reset.
`define SOSWV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i and off during reset.
`define SOSWV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/soswv_pkg.sv
// Types, constants and the sine table builder for the wave vertex engine.
package soswv_pkg;

  typedef struct packed {
    logic signed [23:0] base_x;
    logic signed [23:0] base_y;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic        [31:0] time_s;
  } soswv_in_t;

  typedef struct packed {
    logic signed [31:0] height;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic        [14:0] normal_z;
  } soswv_res_t;

  typedef enum logic [1:0] {
    CFG_WAVE_SPEED     = 2'd0,
    CFG_WAVE_AMPLITUDE = 2'd1,
    CFG_WATER_LEVEL    = 2'd2
  } soswv_cfg_e;

  localparam logic [15:0] SPEED_RST = 16'd256;
  localparam logic [15:0] AMP_RST   = 16'd800;

  // Spatial frequencies in turns per Q.4 unit, scaled by 2^32.
  localparam logic [31:0] KS1 = 32'd85446;
  localparam logic [31:0] KS2 = 32'd128168;
  localparam logic [31:0] KS3 = 32'd42723;
  localparam logic [31:0] KS4 = 32'd213614;
  // Time factors per wave.
  localparam logic [21:0] KT1 = 22'd2670177;
  localparam logic [21:0] KT2 = 22'd1869124;
  localparam logic [21:0] KT3 = 22'd3471230;
  localparam logic [21:0] KT4 = 22'd1335088;

  // Height weights in Q15.
  localparam logic signed [31:0] W2 = 32'sd19661;
  localparam logic signed [31:0] W3 = 32'sd9830;
  localparam logic signed [31:0] W4 = 32'sd6554;
  // Slope factors in Q24.
  localparam logic signed [31:0] GX1 = 32'sd33554;
  localparam logic signed [31:0] G3  = 32'sd5033;
  localparam logic signed [31:0] GY2 = 32'sd30199;

  // Odd polynomial coefficients of sin(pi/2 x), Q30.
  localparam logic [31:0] PC1 = 32'd1686629713;
  localparam logic [31:0] PC3 = 32'd693598668;
  localparam logic [31:0] PC5 = 32'd85569306;
  localparam logic [31:0] PC7 = 32'd5026995;
  localparam logic [31:0] PC9 = 32'd172272;

  // Quarter-wave table entry r of a table with 2^bits entries per turn.
  function automatic logic [14:0] sine_entry(input int unsigned r, input int unsigned bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] v;
    x  = 64'(r) << (32 - bits);
    x2 = (x * x) >> 30;
    p  = 64'(PC9);
    p  = 64'(PC7) - ((x2 * p) >> 30);
    p  = 64'(PC5) - ((x2 * p) >> 30);
    p  = 64'(PC3) - ((x2 * p) >> 30);
    p  = 64'(PC1) - ((x2 * p) >> 30);
    v  = (x * p) >> 30;
    v  = (v + 64'd16384) >> 15;
    return (v > 64'd32767) ? 15'h7fff : v[14:0];
  endfunction

endpackage

>>> rtl/sum_of_sines_wave_vertex.sv
// Sum-of-sines ocean vertex engine: height and unit normal per grid vertex.
//
// Usage. Drive one vertex item on in_i and pulse start; it is taken at any
// clock edge with start high and busy low. busy is tied low, so a vertex can
// enter in every cycle. Each result item appears on res_o for exactly one
// cycle with result_valid_o high, in the order the vertices came in.
// Throughput is one vertex per clock. The chain holds 11 stages of position,
// phase, table lookup, weighting and slope math, 20 stages of the
// bit-per-stage square root, one numerator stage, 16 stages of the three
// parallel bit-per-stage dividers that normalize the slope vector, and the
// output register.
// The receiver cannot stall; results are shown once and then dropped.
// Configuration (wave_speed, wave_amplitude, water_level) is written over
// cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i; ready is always
// high. Write it only while no vertex is in flight. Unknown indexes are
// ignored. Reset clears all valid bits and loads the register defaults;
// no clearing pass is needed, so vertices are taken right after reset.
`include "sum_of_sines_wave_vertex_macros.svh"

module sum_of_sines_wave_vertex import soswv_pkg::*; #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  soswv_in_t   in_i,
  output logic        result_valid_o,
  output soswv_res_t  res_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int QB = SINE_TABLE_BITS - 2;
  localparam int QUARTER = 1 << QB;
  localparam int SQ_N = 20;   // square root stages (40-bit radicand)
  localparam int DV_N = 16;   // divider stages (16-bit quotient)

  typedef struct packed {
    logic signed [31:0] height;
    logic [19:0]        mx;
    logic [19:0]        my;
    logic               sx;
    logic               sy;
  } sq_side_t;

  typedef struct packed {
    logic signed [31:0] height;
    logic               sx;
    logic               sy;
  } dv_side_t;

  // ---------------- configuration ----------------
  logic [15:0]        speed_q;
  logic [15:0]        amp_q;
  logic signed [31:0] level_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= SPEED_RST;
      amp_q   <= AMP_RST;
      level_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (soswv_cfg_e'(cfg_index_i))
        CFG_WAVE_SPEED:     speed_q <= cfg_data_i[15:0];
        CFG_WAVE_AMPLITUDE: amp_q   <= cfg_data_i[15:0];
        CFG_WATER_LEVEL:    level_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- sine table ----------------
  logic [14:0] qtab [QUARTER+1];

  for (genvar gi = 0; gi <= QUARTER; gi++) begin : g_tab
    assign qtab[gi] = sine_entry(gi, SINE_TABLE_BITS);
  end

  function automatic logic signed [15:0] sin_lut(input logic [31:0] ph);
    logic [SINE_TABLE_BITS-1:0] q;
    logic [1:0]                 quad;
    logic [QB:0]                r;
    logic [14:0]                m;
    q    = ph[31 -: SINE_TABLE_BITS];
    quad = q[SINE_TABLE_BITS-1 -: 2];
    r    = {1'b0, q[QB-1:0]};
    if (quad[0]) r = (QB+1)'(QUARTER) - r;
    m = qtab[r];
    return quad[1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  // ---------------- front stages ----------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q, v11_q;

  logic signed [32:0] sum_x, sum_y;
  logic signed [31:0] x1_d, y1_d;
  logic signed [31:0] x1_q, y1_q;
  logic [47:0]        ts1_q;

  logic [31:0] sp2_q [4];
  logic [23:0] th2_q [4];
  logic [45:0] tl2_q [4];
  logic [21:0] kt    [4];

  logic [47:0] tp    [4];
  logic [31:0] ph3_q [7];
  logic signed [15:0] sc4_q [7];

  logic signed [31:0] w5_q [4];
  logic signed [31:0] k5_q [3];

  logic signed [33:0] acc6_q;
  logic signed [31:0] gxs6_q, gys6_q;

  logic signed [50:0] za7_q;
  logic signed [48:0] ga7_q, gb7_q;
  logic signed [31:0] lvl7_q;

  logic signed [21:0] z8;
  logic signed [33:0] h8;
  logic signed [31:0] h8_q;
  logic signed [21:0] gx8_q, gy8_q;

  logic signed [31:0] h9_q;
  logic [19:0]        mx9_q, my9_q;
  logic               sx9_q, sy9_q;

  logic signed [31:0] h10_q;
  logic [19:0]        mx10_q, my10_q;
  logic               sx10_q, sy10_q;
  logic [39:0]        qx10_q, qy10_q;

  sq_side_t    side11_q;
  logic [39:0] n11_q;

  assign kt[0] = KT1;
  assign kt[1] = KT2;
  assign kt[2] = KT3;
  assign kt[3] = KT4;

  // Saturate world position to 32 bits.
  always_comb begin
    sum_x = 33'(in_i.base_x) + 33'(in_i.offset_x);
    sum_y = 33'(in_i.base_y) + 33'(in_i.offset_y);
    x1_d  = (sum_x[32] != sum_x[31]) ? (sum_x[32] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                                     : sum_x[31:0];
    y1_d  = (sum_y[32] != sum_y[31]) ? (sum_y[32] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                                     : sum_y[31:0];
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      tp[i] = {th2_q[i], 24'b0} + 48'(tl2_q[i]);
    end
    for (int i = 0; i < 2; i++) begin
      tp[i] = tp[i];
    end
  end

  always_comb begin
    z8 = 22'((za7_q + (za7_q[50] ? 51'sd536870911 : 51'sd536870912)) >>> 30);
    h8 = 34'(lvl7_q) + 34'(z8);
  end

  always_ff @(posedge clk_i) begin
    // stage 1: position and time scaling
    x1_q  <= x1_d;
    y1_q  <= y1_d;
    ts1_q <= 48'(in_i.time_s) * 48'(speed_q);
    // stage 2: spatial phase products, split time products
    sp2_q[0] <= 32'(x1_q * KS1);
    sp2_q[1] <= 32'(y1_q * KS2);
    sp2_q[2] <= 32'((x1_q + y1_q) * KS3);
    sp2_q[3] <= 32'(x1_q * KS4);
    for (int i = 0; i < 4; i++) begin
      th2_q[i] <= 24'(ts1_q[47:24] * kt[i]);
      tl2_q[i] <= 46'(ts1_q[23:0]) * 46'(kt[i]);
    end
    // stage 3: phases; cosine is a quarter turn ahead
    ph3_q[0] <= sp2_q[0] + tp[0][47:16];
    ph3_q[1] <= sp2_q[1] + tp[1][47:16];
    ph3_q[2] <= sp2_q[2] + tp[2][47:16];
    ph3_q[3] <= sp2_q[3] - tp[3][47:16];
    ph3_q[4] <= sp2_q[0] + tp[0][47:16] + 32'h4000_0000;
    ph3_q[5] <= sp2_q[1] + tp[1][47:16] + 32'h4000_0000;
    ph3_q[6] <= sp2_q[2] + tp[2][47:16] + 32'h4000_0000;
    // stage 4: table lookups
    for (int i = 0; i < 7; i++) begin
      sc4_q[i] <= sin_lut(ph3_q[i]);
    end
    // stage 5: weights and slope factors
    w5_q[0] <= 32'(sc4_q[0]) <<< 15;
    w5_q[1] <= 32'(sc4_q[1]) * W2;
    w5_q[2] <= 32'(sc4_q[2]) * W3;
    w5_q[3] <= 32'(sc4_q[3]) * W4;
    k5_q[0] <= 32'(sc4_q[4]) * GX1;
    k5_q[1] <= 32'(sc4_q[6]) * G3;
    k5_q[2] <= 32'(sc4_q[5]) * GY2;
    // stage 6: sums
    acc6_q <= 34'(w5_q[0]) + 34'(w5_q[1]) + 34'(w5_q[2]) + 34'(w5_q[3]);
    gxs6_q <= k5_q[0] + k5_q[1];
    gys6_q <= k5_q[2] + k5_q[1];
    // stage 7: amplitude scaling
    za7_q  <= 51'(acc6_q) * 51'($signed({1'b0, amp_q}));
    ga7_q  <= 49'(gxs6_q) * 49'($signed({1'b0, amp_q}));
    gb7_q  <= 49'(gys6_q) * 49'($signed({1'b0, amp_q}));
    lvl7_q <= level_q;
    // stage 8: round half away from zero, saturate height
    h8_q  <= (h8[33] != h8[31] || h8[32] != h8[31]) ?
             (h8[33] ? 32'sh8000_0000 : 32'sh7fff_ffff) : h8[31:0];
    gx8_q <= 22'((ga7_q + (ga7_q[48] ? 49'sd67108863 : 49'sd67108864)) >>> 27);
    gy8_q <= 22'((gb7_q + (gb7_q[48] ? 49'sd67108863 : 49'sd67108864)) >>> 27);
    // stage 9: magnitudes
    h9_q  <= h8_q;
    sx9_q <= gx8_q[21];
    sy9_q <= gy8_q[21];
    mx9_q <= 20'(gx8_q[21] ? -gx8_q : gx8_q);
    my9_q <= 20'(gy8_q[21] ? -gy8_q : gy8_q);
    // stage 10: squares
    h10_q  <= h9_q;
    sx10_q <= sx9_q;
    sy10_q <= sy9_q;
    mx10_q <= mx9_q;
    my10_q <= my9_q;
    qx10_q <= 40'(mx9_q) * 40'(mx9_q);
    qy10_q <= 40'(my9_q) * 40'(my9_q);
    // stage 11: radicand, the z term is 1.0 in Q16 squared
    n11_q           <= qx10_q + qy10_q + 40'h01_0000_0000;
    side11_q.height <= h10_q;
    side11_q.mx     <= mx10_q;
    side11_q.my     <= my10_q;
    side11_q.sx     <= sx10_q;
    side11_q.sy     <= sy10_q;
  end

  // ---------------- square root, one root bit per stage ----------------
  logic               sqv_q    [SQ_N];
  logic [39:0]        sqn_q    [SQ_N];
  logic [21:0]        sqrem_q  [SQ_N];
  logic [19:0]        sqroot_q [SQ_N];
  sq_side_t           sqside_q [SQ_N];
  logic [39:0]        sqn_d    [SQ_N];
  logic [21:0]        sqrem_d  [SQ_N];
  logic [19:0]        sqroot_d [SQ_N];
  logic [23:0]        sq_t     [SQ_N];
  logic [23:0]        sq_trial [SQ_N];

  always_comb begin
    for (int k = 0; k < SQ_N; k++) begin
      sq_t[k]     = {sqrem_q[k], sqn_q[k][39:38]};
      sq_trial[k] = {2'b00, sqroot_q[k], 2'b01};
      sqn_d[k]    = sqn_q[k] << 2;
      if (sq_t[k] >= sq_trial[k]) begin
        sqrem_d[k]  = 22'(sq_t[k] - sq_trial[k]);
        sqroot_d[k] = {sqroot_q[k][18:0], 1'b1};
      end else begin
        sqrem_d[k]  = 22'(sq_t[k]);
        sqroot_d[k] = {sqroot_q[k][18:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sqn_q[0]    <= n11_q;
    sqrem_q[0]  <= '0;
    sqroot_q[0] <= '0;
    sqside_q[0] <= side11_q;
    for (int k = 1; k < SQ_N; k++) begin
      sqn_q[k]    <= sqn_d[k-1];
      sqrem_q[k]  <= sqrem_d[k-1];
      sqroot_q[k] <= sqroot_d[k-1];
      sqside_q[k] <= sqside_q[k-1];
    end
  end

  // ---------------- numerators ----------------
  logic        num_v_q;
  logic [19:0] num_len_q;
  logic [35:0] num_q [3];
  dv_side_t    num_side_q;

  always_ff @(posedge clk_i) begin
    num_len_q         <= sqroot_d[SQ_N-1];
    num_q[0]          <= {1'b0, sqside_q[SQ_N-1].mx, 15'b0} + 36'(sqroot_d[SQ_N-1][19:1]);
    num_q[1]          <= {1'b0, sqside_q[SQ_N-1].my, 15'b0} + 36'(sqroot_d[SQ_N-1][19:1]);
    num_q[2]          <= 36'h0_8000_0000 + 36'(sqroot_d[SQ_N-1][19:1]);
    num_side_q.height <= sqside_q[SQ_N-1].height;
    num_side_q.sx     <= sqside_q[SQ_N-1].sx;
    num_side_q.sy     <= sqside_q[SQ_N-1].sy;
  end

  // ---------------- dividers, three lanes, one quotient bit per stage -------
  logic        dvv_q  [DV_N];
  logic [19:0] dd_q   [DV_N];
  logic [19:0] dr_q   [DV_N][3];
  logic [15:0] dn_q   [DV_N][3];
  logic [15:0] dq_q   [DV_N][3];
  dv_side_t    dside_q[DV_N];
  logic [20:0] dv_t   [DV_N][3];
  logic [19:0] dr_d   [DV_N][3];
  logic [15:0] dq_d   [DV_N][3];

  always_comb begin
    for (int k = 0; k < DV_N; k++) begin
      for (int l = 0; l < 3; l++) begin
        dv_t[k][l] = {dr_q[k][l], dn_q[k][l][15]};
        if (dv_t[k][l] >= {1'b0, dd_q[k]}) begin
          dr_d[k][l] = 20'(dv_t[k][l] - {1'b0, dd_q[k]});
          dq_d[k][l] = {dq_q[k][l][14:0], 1'b1};
        end else begin
          dr_d[k][l] = dv_t[k][l][19:0];
          dq_d[k][l] = {dq_q[k][l][14:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dd_q[0]    <= num_len_q;
    dside_q[0] <= num_side_q;
    for (int l = 0; l < 3; l++) begin
      dr_q[0][l] <= num_q[l][35:16];
      dn_q[0][l] <= num_q[l][15:0];
      dq_q[0][l] <= '0;
    end
    for (int k = 1; k < DV_N; k++) begin
      dd_q[k]    <= dd_q[k-1];
      dside_q[k] <= dside_q[k-1];
      for (int l = 0; l < 3; l++) begin
        dr_q[k][l] <= dr_d[k-1][l];
        dn_q[k][l] <= dn_q[k-1][l] << 1;
        dq_q[k][l] <= dq_d[k-1][l];
      end
    end
  end

  // ---------------- output register ----------------
  logic [14:0] nx_mag, ny_mag, nz_mag;
  soswv_res_t  res_d;
  soswv_res_t  res_q;
  logic        out_v_q;

  always_comb begin
    nx_mag = (dq_d[DV_N-1][0] > 16'd32767) ? 15'h7fff : dq_d[DV_N-1][0][14:0];
    ny_mag = (dq_d[DV_N-1][1] > 16'd32767) ? 15'h7fff : dq_d[DV_N-1][1][14:0];
    nz_mag = (dq_d[DV_N-1][2] > 16'd32767) ? 15'h7fff : dq_d[DV_N-1][2][14:0];
    res_d.height   = dside_q[DV_N-1].height;
    // Normal points against the slope: negate when the slope is positive.
    res_d.normal_x = dside_q[DV_N-1].sx ? $signed({1'b0, nx_mag})
                                        : -$signed({1'b0, nx_mag});
    res_d.normal_y = dside_q[DV_N-1].sy ? $signed({1'b0, ny_mag})
                                        : -$signed({1'b0, ny_mag});
    res_d.normal_z = nz_mag;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // ---------------- valid chain ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      v6_q    <= 1'b0;
      v7_q    <= 1'b0;
      v8_q    <= 1'b0;
      v9_q    <= 1'b0;
      v10_q   <= 1'b0;
      v11_q   <= 1'b0;
      num_v_q <= 1'b0;
      out_v_q <= 1'b0;
      for (int k = 0; k < SQ_N; k++) sqv_q[k] <= 1'b0;
      for (int k = 0; k < DV_N; k++) dvv_q[k] <= 1'b0;
    end else begin
      v1_q     <= start && !busy;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      v4_q     <= v3_q;
      v5_q     <= v4_q;
      v6_q     <= v5_q;
      v7_q     <= v6_q;
      v8_q     <= v7_q;
      v9_q     <= v8_q;
      v10_q    <= v9_q;
      v11_q    <= v10_q;
      sqv_q[0] <= v11_q;
      for (int k = 1; k < SQ_N; k++) sqv_q[k] <= sqv_q[k-1];
      num_v_q  <= sqv_q[SQ_N-1];
      dvv_q[0] <= num_v_q;
      for (int k = 1; k < DV_N; k++) dvv_q[k] <= dvv_q[k-1];
      out_v_q  <= dvv_q[DV_N-1];
    end
  end

  assign result_valid_o = out_v_q;
  assign res_o          = res_q;

  // ---------------- assertions ----------------
  // The radicand always holds 2^32, so the root is at least 1.0 in Q16.
  `SOSWV_ASSERT_NOW(a_len_floor, num_v_q, num_len_q >= 20'd65536, "norm length below one")
  // The slope vector is bounded, so the vertical component stays large.
  `SOSWV_ASSERT_NOW(a_nz_floor, result_valid_o, res_o.normal_z >= 15'd2048, "normal_z too small")
  // An item in the numerator stage enters the dividers next cycle.
  `SOSWV_ASSERT_NEXT(a_div_enter, num_v_q, dvv_q[0], "item lost before divider")
  // Restoring division keeps the remainder below the divisor.
  `SOSWV_ASSERT_NOW(a_div_rem, dvv_q[DV_N-1], dr_q[DV_N-1][2] < dd_q[DV_N-1],
                    "divider remainder out of range")

endmodule

>>> test/tb_sum_of_sines_wave_vertex.sv
// Self-checking testbench for the sum-of-sines wave vertex engine.
module tb_sum_of_sines_wave_vertex;
  import soswv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_BITS = 10;
  localparam int LATENCY = 49;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  soswv_in_t in_i = '0;
  logic result_valid_o;
  soswv_res_t res_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  sum_of_sines_wave_vertex #(.SINE_TABLE_BITS(TABLE_BITS)) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the configuration registers.
  logic [15:0] speed_q = SPEED_RST;
  logic [15:0] amp_q = AMP_RST;
  logic signed [31:0] level_q = '0;

  soswv_res_t surface_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  longint cycles = 0;

  // Sine of a turn-count phase from the quarter-wave Taylor table.
  function automatic longint sine_of(logic [31:0] phase);
    logic [31:0] q;
    logic [1:0] quad;
    longint unsigned r, x, x2, p, v;
    longint mag;
    q = phase >> (32 - TABLE_BITS);
    quad = q[TABLE_BITS-1 -: 2];
    r = q & ((1 << (TABLE_BITS - 2)) - 1);
    if (quad[0]) r = (1 << (TABLE_BITS - 2)) - r;
    x = r << (32 - TABLE_BITS);
    x2 = (x * x) >> 30;
    p = 64'd172272;
    p = 64'd5026995 - ((x2 * p) >> 30);
    p = 64'd85569306 - ((x2 * p) >> 30);
    p = 64'd693598668 - ((x2 * p) >> 30);
    p = 64'd1686629713 - ((x2 * p) >> 30);
    v = (x * p) >> 30;
    v = (v + 64'd16384) >> 15;
    mag = (v > 32767) ? 32767 : longint'(v);
    return quad[1] ? -mag : mag;
  endfunction

  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Round right shift, half away from zero.
  function automatic longint round_away(longint v, int s);
    longint unsigned half;
    half = 64'd1 << (s - 1);
    if (v >= 0) return longint'((longint'(v) + half) >> s);
    return -longint'((longint'(-v) + half) >> s);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned acc, bitv;
    acc = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= acc + bitv) begin
        n -= acc + bitv;
        acc = (acc >> 1) + bitv;
      end else begin
        acc >>= 1;
      end
      bitv >>= 2;
    end
    return acc;
  endfunction

  function automatic logic [15:0] normal_part(longint g, longint unsigned len);
    longint unsigned mag, v;
    mag = (g < 0) ? longint'(-g) : longint'(g);
    v = ((mag << 15) + (len >> 1)) / len;
    if (v > 32767) v = 32767;
    return (g < 0) ? 16'(v) : 16'(-longint'(v));
  endfunction

  function automatic soswv_res_t surface_of(soswv_in_t v);
    soswv_res_t r;
    longint x, y, xy, acc, z, amp, gx, gy, c1, c2, c3;
    longint unsigned ts, len, nz;
    logic [31:0] p1, p2, p3, p4;
    x = sat_word(longint'(v.base_x) + longint'(v.offset_x));
    y = sat_word(longint'(v.base_y) + longint'(v.offset_y));
    xy = x + y;
    ts = longint'(v.time_s) * longint'(speed_q);
    amp = longint'(amp_q);
    p1 = 32'(x * KS1) + 32'((ts * KT1) >> 16);
    p2 = 32'(y * KS2) + 32'((ts * KT2) >> 16);
    p3 = 32'(xy * KS3) + 32'((ts * KT3) >> 16);
    p4 = 32'(x * KS4) - 32'((ts * KT4) >> 16);
    acc = sine_of(p1) * 32768 + sine_of(p2) * 19661 + sine_of(p3) * 9830
        + sine_of(p4) * 6554;
    z = round_away(acc * amp, 30);
    r.height = 32'(sat_word(longint'(level_q) + z));
    c1 = sine_of(p1 + 32'h4000_0000);
    c2 = sine_of(p2 + 32'h4000_0000);
    c3 = sine_of(p3 + 32'h4000_0000);
    gx = round_away(amp * (33554 * c1 + 5033 * c3), 27);
    gy = round_away(amp * (30199 * c2 + 5033 * c3), 27);
    len = root_floor(gx * gx + gy * gy + (64'd1 << 32));
    r.normal_x = normal_part(gx, len);
    r.normal_y = normal_part(gy, len);
    nz = ((64'd1 << 31) + (len >> 1)) / len;
    if (nz > 32767) nz = 32767;
    r.normal_z = 15'(nz);
    return r;
  endfunction

  // Send one vertex item, idling first at the current rate.
  task automatic send_vertex(soswv_in_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    in_i <= v;
    do @(posedge clk_i); while (busy);
    surface_q.push_back(surface_of(v));
  endtask

  // Drop start, wait for every result, then hold for the latency.
  task automatic drain_pipe();
    start <= 1'b0;
    while (surface_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(soswv_cfg_e idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_WAVE_SPEED: speed_q = data[15:0];
      CFG_WAVE_AMPLITUDE: amp_q = data[15:0];
      CFG_WATER_LEVEL: level_q = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic soswv_in_t random_vertex();
    soswv_in_t v;
    v.base_x = $urandom;
    v.base_y = $urandom;
    v.time_s = $urandom;
    // Mostly grid-sized offsets; sometimes full range to force saturation.
    if ($urandom_range(3) == 0) begin
      v.offset_x = $urandom;
      v.offset_y = $urandom;
    end else begin
      v.offset_x = 32'($signed($urandom_range(200000)) - 100000);
      v.offset_y = 32'($signed($urandom_range(200000)) - 100000);
    end
    return v;
  endfunction

  // Drive the field extremes, saturating positions and flat surface.
  task automatic test_directed();
    soswv_in_t v;
    logic signed [23:0] bext[3] = '{24'sh800000, 24'sh7fffff, 24'sd0};
    logic signed [31:0] oext[3] = '{32'sh80000000, 32'sh7fffffff, 32'sd0};
    for (int i = 0; i < 9; i++) begin
      v.base_x = bext[i % 3];
      v.base_y = bext[(i + 1) % 3];
      v.offset_x = oext[i / 3];
      v.offset_y = oext[(i + 2) % 3];
      v.time_s = (i % 2) ? 32'hffff_ffff : 32'd0;
      send_vertex(v);
    end
    drain_pipe();
    // Flat surface: zero amplitude gives a straight-up normal.
    write_reg(CFG_WAVE_AMPLITUDE, 32'd0);
    send_vertex(random_vertex());
    drain_pipe();
    // Largest amplitude with extreme water levels overflows the height.
    write_reg(CFG_WAVE_AMPLITUDE, 32'hffff);
    write_reg(CFG_WATER_LEVEL, 32'h7fff_ffff);
    for (int i = 0; i < 4; i++) send_vertex(random_vertex());
    drain_pipe();
    write_reg(CFG_WATER_LEVEL, 32'h8000_0000);
    write_reg(CFG_WAVE_SPEED, 32'hffff);
    for (int i = 0; i < 4; i++) send_vertex(random_vertex());
    drain_pipe();
    write_reg(CFG_WAVE_SPEED, 32'd0);
    for (int i = 0; i < 3; i++) send_vertex(random_vertex());
    drain_pipe();
  endtask

  // Random vertices over three idle profiles and several settings.
  task automatic test_random();
    int pct[3] = '{12, 68, 0};
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = pct[ph];
      write_reg(CFG_WAVE_SPEED, $urandom);
      write_reg(CFG_WAVE_AMPLITUDE, (ph == 2) ? 32'(AMP_RST) : $urandom);
      write_reg(CFG_WATER_LEVEL, $urandom);
      for (int i = 0; i < 580; i++) begin
        send_vertex(random_vertex());
        // Pause once until every result is back.
        if (ph == 1 && i == 300) begin
          drain_pipe();
        end
      end
      drain_pipe();
    end
  endtask

  // Compare each result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (surface_q.size() == 0) begin
        $error("unexpected result item");
        errors++;
      end else begin
        soswv_res_t e;
        e = surface_q.pop_front();
        if (res_o.height !== e.height) begin
          $error("height exp %0d got %0d", e.height, res_o.height);
          errors++;
        end
        if (res_o.normal_x !== e.normal_x) begin
          $error("normal_x exp %0d got %0d", e.normal_x, res_o.normal_x);
          errors++;
        end
        if (res_o.normal_y !== e.normal_y) begin
          $error("normal_y exp %0d got %0d", e.normal_y, res_o.normal_y);
          errors++;
        end
        if (res_o.normal_z !== e.normal_z) begin
          $error("normal_z exp %0d got %0d", e.normal_z, res_o.normal_z);
          errors++;
        end
      end
    end
  end

  // Watchdog on the total cycle count.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    if (errors == 0 && surface_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

>>> sum_of_sines_wave_vertex.f
+incdir+rtl
rtl/soswv_pkg.sv
rtl/sum_of_sines_wave_vertex.sv
test/tb_sum_of_sines_wave_vertex.sv
